// File: rtl/core/fsa_pkg.sv
// Shared constants and control types for the free list slot allocator.
package fsa_pkg;

  // Default pool size, fixed field widths and reset slot count.
  localparam int DEFAULT_POOL_DEPTH = 64;
  localparam int IDX_W              = 6;
  localparam int CFG_W              = 7;
  localparam int RESET_SLOT_COUNT   = 64;

  // Request codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rebuild;  // load slot count, reset head and restart the ring sweep
    logic sweep;    // write one ring entry and advance the sweep counter
    logic accept;   // latch the request and start the memory read
    logic exec;     // apply the request and load the result register
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;  // sweep counter is on the last memory entry
  } status_t;

endpackage

// File: rtl/core/free_list_slot_allocator.sv
// out_valid rises once the request has passed the EXEC state, which waits for a free output.
// Requests are handled one at a time: a new request is not taken until the last one
// leaves EXEC, as the link memory read must finish before the head pointer updates.
// Reset (rst, synchronous, active high) and every slot_count write start a sweep over
// all POOL_DEPTH entries that rebuilds the ring; in_ready stays low during the sweep.
// Top level of the free list slot allocator.
module free_list_slot_allocator #(
  parameter int POOL_DEPTH = fsa_pkg::DEFAULT_POOL_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fsa_pkg::CFG_W-1:0] slot_count,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      command,
  input  logic [fsa_pkg::IDX_W-1:0] release_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      ok,
  output logic [fsa_pkg::IDX_W-1:0] slot_index
);

  fsa_pkg::ctrl_t   ctrl;
  fsa_pkg::status_t status;

  // Control sequencing.
  fsa_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl),
    .status    (status)
  );

  // Storage and request datapath.
  fsa_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .cfg_data      (slot_count),
    .command       (command),
    .release_index (release_index),
    .ok            (ok),
    .slot_index    (slot_index)
  );

endmodule

// File: rtl/core/fsa_ram.sv
// Generic single write port, single read port RAM with registered read.
module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/fsa_datapath.sv
// Datapath: slot count, head pointer, ring sweep, link memory and result register.
module fsa_datapath #(
  parameter int POOL_DEPTH = fsa_pkg::DEFAULT_POOL_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fsa_pkg::ctrl_t            ctrl,
  output fsa_pkg::status_t          status,
  input  logic [fsa_pkg::CFG_W-1:0] cfg_data,
  input  logic                      command,
  input  logic [fsa_pkg::IDX_W-1:0] release_index,
  output logic                      ok,
  output logic [fsa_pkg::IDX_W-1:0] slot_index
);

  localparam int SLOT_W = $clog2(POOL_DEPTH);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int CMP_W  = (CNT_W > fsa_pkg::CFG_W) ? CNT_W : fsa_pkg::CFG_W;
  localparam int MEM_W  = SLOT_W + 1;
  localparam int RST_COUNT = (fsa_pkg::RESET_SLOT_COUNT > POOL_DEPTH) ?
                             POOL_DEPTH : fsa_pkg::RESET_SLOT_COUNT;

  logic [CNT_W-1:0]          slot_count;
  logic [SLOT_W-1:0]         head;
  logic [SLOT_W-1:0]         sweep_idx;
  logic                      req_cmd;
  logic [fsa_pkg::IDX_W-1:0] req_idx;

  logic [CMP_W-1:0]  cfg_wide;
  logic [CMP_W-1:0]  cfg_sat;
  logic [CNT_W-1:0]  sweep_next;
  logic [SLOT_W-1:0] ring_link;
  logic [CMP_W-1:0]  in_idx_wide;
  logic [CMP_W-1:0]  req_idx_wide;
  logic [SLOT_W-1:0] req_slot;
  logic              req_in_range;
  logic              rd_free;
  logic [SLOT_W-1:0] rd_link;
  logic              alloc_ok;
  logic              op_ok;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [MEM_W-1:0]  wr_data;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [MEM_W-1:0]  rd_data;

  // Written slot count: zero acts as one, and it saturates at the pool depth.
  always_comb begin
    cfg_wide = CMP_W'(cfg_data);
    if (cfg_wide == '0) begin
      cfg_sat = CMP_W'(1);
    end else if (cfg_wide > CMP_W'(POOL_DEPTH)) begin
      cfg_sat = CMP_W'(POOL_DEPTH);
    end else begin
      cfg_sat = cfg_wide;
    end
  end

  // Ring entry for the sweep: slot i links to i+1, wrapping at the slot count.
  assign sweep_next = CNT_W'(sweep_idx) + CNT_W'(1);
  assign ring_link  = (sweep_next >= slot_count) ? '0 : sweep_next[SLOT_W-1:0];
  assign status.sweep_last = (sweep_idx == SLOT_W'(POOL_DEPTH - 1));

  // Request decode against the latched release index.
  assign in_idx_wide  = CMP_W'(release_index);
  assign req_idx_wide = CMP_W'(req_idx);
  assign req_slot     = req_idx_wide[SLOT_W-1:0];
  assign req_in_range = (req_idx_wide < CMP_W'(slot_count));
  assign rd_free      = rd_data[SLOT_W];
  assign rd_link      = rd_data[SLOT_W-1:0];
  assign alloc_ok     = rd_free && (CNT_W'(head) < slot_count);
  assign op_ok        = (req_cmd == fsa_pkg::CMD_ALLOC) ? alloc_ok : req_in_range;

  // Memory read: the head entry for an allocate, the released entry otherwise.
  assign rd_en   = ctrl.accept;
  assign rd_addr = (command == fsa_pkg::CMD_RELEASE) ? in_idx_wide[SLOT_W-1:0] : head;

  // Memory write: ring sweep, or the entry touched by the request.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_idx;
    wr_data = {1'b1, ring_link};
    if (ctrl.sweep) begin
      wr_en = 1'b1;
    end else if (ctrl.exec && op_ok) begin
      wr_en = 1'b1;
      if (req_cmd == fsa_pkg::CMD_ALLOC) begin
        wr_addr = head;
        wr_data = {1'b0, rd_link};
      end else begin
        wr_addr = req_slot;
        wr_data = {1'b1, (head == req_slot) ? rd_link : head};
      end
    end
  end

  fsa_ram #(
    .WIDTH (MEM_W),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Slot count, head pointer and sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= CNT_W'(RST_COUNT);
      head       <= '0;
      sweep_idx  <= '0;
    end else if (ctrl.rebuild) begin
      slot_count <= cfg_sat[CNT_W-1:0];
      head       <= '0;
      sweep_idx  <= '0;
    end else begin
      if (ctrl.sweep) begin
        sweep_idx <= sweep_idx + SLOT_W'(1);
      end
      if (ctrl.exec && op_ok) begin
        if (req_cmd == fsa_pkg::CMD_ALLOC) begin
          head <= rd_link;
        end else begin
          head <= req_slot;
        end
      end
    end
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      req_cmd <= command;
      req_idx <= release_index;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      ok <= op_ok;
      if (req_cmd == fsa_pkg::CMD_RELEASE) begin
        slot_index <= req_idx;
      end else if (alloc_ok) begin
        slot_index <= fsa_pkg::IDX_W'(head);
      end else begin
        slot_index <= '0;
      end
    end
  end

endmodule

// File: rtl/core/fsa_controller.sv
// Controller: sequences the ring sweep, request handling and result handshake.
module fsa_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fsa_pkg::ctrl_t   ctrl,
  input  fsa_pkg::status_t status
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // A slot count write waits for a request in progress, and it takes
  // priority over a request offered in the same cycle.
  assign cfg_ready = (state != ST_EXEC);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign out_free  = !out_valid || out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    ctrl.rebuild = 1'b0;
    ctrl.sweep   = 1'b0;
    ctrl.accept  = 1'b0;
    ctrl.exec    = 1'b0;
    case (state)
      ST_CLEAR: begin
        ctrl.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.accept = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          ctrl.exec  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // A slot count write rebuilds the ring from the first entry.
    if (cfg_valid && cfg_ready) begin
      ctrl.rebuild = 1'b1;
      ctrl.sweep   = 1'b0;
      ctrl.accept  = 1'b0;
      ctrl.exec    = 1'b0;
      state_next   = ST_CLEAR;
    end
  end

  // State register; reset starts the ring sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Result valid: set when a request completes, cleared by an output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/fsa_checker.sv
// Port level checks for the free list slot allocator, bound to the top level.
module fsa_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      ok,
  input logic [fsa_pkg::IDX_W-1:0] slot_index
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(slot_index))
    else $error("result changed while stalled");

  // Requests are handled one at a time: no transfer right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an input transfer");

  // A slot count write starts the ring rebuild, which blocks requests.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input ready right after a slot count write");

  // A new result only appears while a request is in progress.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in progress");

endmodule

bind free_list_slot_allocator fsa_checker u_fsa_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .ok         (ok),
  .slot_index (slot_index)
);
